// ===== hdl/dpu_pkg.sv =====
// dpu_pkg: shared types, constants and codes for the depth pixel unprojection core
// covers payload structs, configuration layout, controller states and commands
// no dependencies
package dpu_pkg;

  // raster limits and derived counter widths
  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int REM_STEPS  = (COL_W > ROW_W) ? COL_W : ROW_W;
  localparam int STEP_W     = $clog2(REM_STEPS);

  // configuration port
  localparam int CFG_DATA_W = 48;
  localparam int CFG_IDX_W  = 3;

  // datapath widths
  localparam int MUL_W  = 24;
  localparam int PROD_W = 2 * MUL_W;
  localparam int MAG_W  = 16;
  localparam int Z_W    = 23;
  localparam int ZQ_W   = 32;
  localparam int INV_W  = 24;
  localparam int MAGP_W = MAG_W + Z_W;
  localparam int ACC_W  = MAGP_W + INV_W;
  localparam int CNT_W  = 22;

  localparam logic [CNT_W-1:0] POINT_LIMIT = 22'h3FFFFF;

  // register reset values
  localparam logic [7:0]  RST_ROW_STRIDE    = 8'd1;
  localparam logic [7:0]  RST_COLUMN_STRIDE = 8'd1;
  localparam logic [23:0] RST_DEPTH_SCALE   = 24'd16777;
  localparam logic [22:0] RST_NEAR_LIMIT    = 23'd0;
  localparam logic [22:0] RST_FAR_LIMIT     = 23'd655360;
  localparam logic [31:0] RST_PRINCIPAL     = 32'd0;
  localparam logic [47:0] RST_INV_FOCAL     = 48'd0;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW_STRIDE    = 3'd0,
    REG_COLUMN_STRIDE = 3'd1,
    REG_DEPTH_SCALE   = 3'd2,
    REG_NEAR_LIMIT    = 3'd3,
    REG_FAR_LIMIT     = 3'd4,
    REG_PRINCIPAL     = 3'd5,
    REG_INV_FOCAL     = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [7:0]  row_stride;
    logic [7:0]  column_stride;
    logic [23:0] depth_unit_scale;
    logic [22:0] near_limit;
    logic [22:0] far_limit;
    logic [31:0] principal_point;
    logic [47:0] inverse_focal;
  } cfg_t;

  // payloads
  typedef struct packed {
    logic [15:0] depth_raw;
    logic        frame_first;
    logic        row_last;
    logic        frame_final;
  } pix_in_t;

  typedef struct packed {
    logic               point_valid;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic [22:0]        point_z;
    logic               frame_done;
    logic [CNT_W-1:0]   points_so_far;
  } point_out_t;

  // controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_REM,
    S_ZMUL,
    S_XMAG,
    S_XLO,
    S_XHI,
    S_YMAG,
    S_YLO,
    S_YHI,
    S_DONE
  } ctrl_state_t;

  // datapath operations
  typedef enum logic [3:0] {
    OP_NONE,
    OP_REM,
    OP_ZMUL,
    OP_XMAG,
    OP_XLO,
    OP_XHI,
    OP_YMAG,
    OP_YLO,
    OP_YHI
  } op_t;

  typedef struct packed {
    logic load;
    op_t  op;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_status_t;

endpackage

// ===== hdl/dpu_cfg_regs.sv =====
// dpu_cfg_regs: configuration register file of the unprojection core
// decodes the plain write port into a cfg_t bundle
// depends on dpu_pkg
module dpu_cfg_regs import dpu_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  // register writes, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.row_stride       <= RST_ROW_STRIDE;
      cfg.column_stride    <= RST_COLUMN_STRIDE;
      cfg.depth_unit_scale <= RST_DEPTH_SCALE;
      cfg.near_limit       <= RST_NEAR_LIMIT;
      cfg.far_limit        <= RST_FAR_LIMIT;
      cfg.principal_point  <= RST_PRINCIPAL;
      cfg.inverse_focal    <= RST_INV_FOCAL;
    end else if (cfg_write) begin
      unique case (reg_idx_t'(cfg_index))
        REG_ROW_STRIDE:    cfg.row_stride       <= cfg_data[7:0];
        REG_COLUMN_STRIDE: cfg.column_stride    <= cfg_data[7:0];
        REG_DEPTH_SCALE:   cfg.depth_unit_scale <= cfg_data[23:0];
        REG_NEAR_LIMIT:    cfg.near_limit       <= cfg_data[22:0];
        REG_FAR_LIMIT:     cfg.far_limit        <= cfg_data[22:0];
        REG_PRINCIPAL:     cfg.principal_point  <= cfg_data[31:0];
        REG_INV_FOCAL:     cfg.inverse_focal    <= cfg_data[47:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== hdl/dpu_ctrl.sv =====
// dpu_ctrl: sequencing state machine of the unprojection core
// steps the datapath through remainder, depth and projection phases
// depends on dpu_pkg
module dpu_ctrl import dpu_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd
);

  ctrl_state_t       state;
  ctrl_state_t       state_next;
  logic [STEP_W-1:0] step;
  logic              rem_last;

  assign rem_last = (step == STEP_W'(REM_STEPS - 1));

  // state and remainder step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      if (state == S_IDLE) begin
        step <= '0;
      end else if (state == S_REM) begin
        step <= step + STEP_W'(1);
      end
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_valid) state_next = S_REM;
      S_REM:  if (rem_last) state_next = S_ZMUL;
      S_ZMUL: state_next = S_XMAG;
      S_XMAG: state_next = S_XLO;
      S_XLO:  state_next = S_XHI;
      S_XHI:  state_next = S_YMAG;
      S_YMAG: state_next = S_YLO;
      S_YLO:  state_next = S_YHI;
      S_YHI:  state_next = S_DONE;
      S_DONE: if (status.out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // commands to the datapath
  always_comb begin
    in_stall     = 1'b1;
    cmd.load     = 1'b0;
    cmd.op       = OP_NONE;
    cmd.out_load = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      S_REM:  cmd.op = OP_REM;
      S_ZMUL: cmd.op = OP_ZMUL;
      S_XMAG: cmd.op = OP_XMAG;
      S_XLO:  cmd.op = OP_XLO;
      S_XHI:  cmd.op = OP_XHI;
      S_YMAG: cmd.op = OP_YMAG;
      S_YLO:  cmd.op = OP_YLO;
      S_YHI:  cmd.op = OP_YHI;
      S_DONE: cmd.out_load = status.out_free;
      default: ;
    endcase
  end

endmodule

// ===== hdl/dpu_datapath.sv =====
// dpu_datapath: counters, stride remainders, shared multiplier and output register
// carries out the operations that dpu_ctrl issues one per cycle
// depends on dpu_pkg
module dpu_datapath import dpu_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  ctrl_cmd_t  cmd,
  output dp_status_t status,
  input  pix_in_t    in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output point_out_t out_data
);

  // raster counters
  logic [COL_W-1:0] col_cnt;
  logic [ROW_W-1:0] row_cnt;
  logic [CNT_W-1:0] pt_cnt;

  // per-pixel working registers
  logic [15:0]          raw_r;
  logic                 final_r;
  logic [COL_W-1:0]     u_cur;
  logic [ROW_W-1:0]     v_cur;
  logic [CNT_W-1:0]     pc_base;
  logic [REM_STEPS-1:0] u_sh;
  logic [REM_STEPS-1:0] v_sh;
  logic [7:0]           rem_u;
  logic [7:0]           rem_v;
  logic [MAG_W-1:0]     mag_x;
  logic [MAG_W-1:0]     mag_y;
  logic                 neg_x;
  logic                 neg_y;
  logic [ZQ_W-1:0]      zq;
  logic [MAGP_W-1:0]    magp;
  logic [ACC_W-1:0]     acc_x;
  logic [ACC_W-1:0]     acc_y;

  // combinational helpers
  logic [COL_W-1:0]  u_eff;
  logic [ROW_W-1:0]  v_eff;
  logic [7:0]        rs_eff;
  logic [7:0]        cs_eff;
  logic [8:0]        t_u;
  logic [8:0]        t_v;
  logic [MAG_W-1:0]  ax;
  logic [MAG_W-1:0]  ay;
  logic [MAG_W-1:0]  cx;
  logic [MAG_W-1:0]  cy;
  logic [INV_W-1:0]  inv_fx;
  logic [INV_W-1:0]  inv_fy;
  logic [MUL_W-1:0]  mul_a;
  logic [MUL_W-1:0]  mul_b;
  logic [PROD_W-1:0] prod;
  logic [PROD_W-1:0] zsum;
  logic              point_ok;
  logic [CNT_W-1:0]  cnt_next;

  // rounds 44 fraction bits to 16, half away from zero, then saturates
  function automatic logic signed [31:0] round_sat(input logic [ACC_W-1:0] acc,
                                                   input logic neg);
    logic [63:0] sum;
    logic [35:0] r;
    logic [31:0] m;
    sum = 64'(acc) + 64'h0000_0000_0800_0000;
    r   = sum[63:28];
    if (neg) begin
      m = (r > 36'h0_8000_0000) ? 32'h8000_0000 : r[31:0];
      round_sat = 32'(32'h0 - m);
    end else begin
      round_sat = (r > 36'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : r[31:0];
    end
  endfunction

  assign u_eff  = in_data.frame_first ? '0 : col_cnt;
  assign v_eff  = in_data.frame_first ? '0 : row_cnt;
  assign rs_eff = (cfg.row_stride == 8'd0) ? 8'd1 : cfg.row_stride;
  assign cs_eff = (cfg.column_stride == 8'd0) ? 8'd1 : cfg.column_stride;
  assign t_u    = {rem_u, u_sh[REM_STEPS-1]};
  assign t_v    = {rem_v, v_sh[REM_STEPS-1]};
  assign ax     = MAG_W'({u_cur, 4'b0000});
  assign ay     = MAG_W'({v_cur, 4'b0000});
  assign cx     = cfg.principal_point[31:16];
  assign cy     = cfg.principal_point[15:0];
  assign inv_fx = cfg.inverse_focal[47:24];
  assign inv_fy = cfg.inverse_focal[23:0];

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_ZMUL: begin
        mul_a = MUL_W'(raw_r);
        mul_b = cfg.depth_unit_scale;
      end
      OP_XMAG: begin
        mul_a = MUL_W'(mag_x);
        mul_b = MUL_W'(zq[Z_W-1:0]);
      end
      OP_YMAG: begin
        mul_a = MUL_W'(mag_y);
        mul_b = MUL_W'(zq[Z_W-1:0]);
      end
      OP_XLO: begin
        mul_a = magp[MUL_W-1:0];
        mul_b = inv_fx;
      end
      OP_YLO: begin
        mul_a = magp[MUL_W-1:0];
        mul_b = inv_fy;
      end
      OP_XHI: begin
        mul_a = MUL_W'(magp[MAGP_W-1:MUL_W]);
        mul_b = inv_fx;
      end
      OP_YHI: begin
        mul_a = MUL_W'(magp[MAGP_W-1:MUL_W]);
        mul_b = inv_fy;
      end
      default: ;
    endcase
  end

  assign prod = mul_a * mul_b;
  assign zsum = prod + PROD_W'(128);

  // point decision and saturating count
  assign point_ok = (raw_r != 16'd0) && (rem_u == 8'd0) && (rem_v == 8'd0) &&
                    (zq >= ZQ_W'(cfg.near_limit)) && (zq <= ZQ_W'(cfg.far_limit));
  assign cnt_next = !point_ok ? pc_base :
                    (pc_base == POINT_LIMIT) ? pc_base : pc_base + CNT_W'(1);

  assign status.out_free = !out_valid || !out_stall;

  // raster and point counters
  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt <= '0;
      row_cnt <= '0;
      pt_cnt  <= '0;
    end else begin
      if (cmd.load) begin
        if (in_data.frame_final) begin
          col_cnt <= '0;
          row_cnt <= '0;
        end else if (in_data.row_last) begin
          col_cnt <= '0;
          row_cnt <= (v_eff == ROW_W'(MAX_HEIGHT - 1)) ? '0 : v_eff + ROW_W'(1);
        end else begin
          col_cnt <= (u_eff == COL_W'(MAX_WIDTH - 1)) ? '0 : u_eff + COL_W'(1);
          row_cnt <= v_eff;
        end
      end
      if (cmd.out_load) begin
        pt_cnt <= final_r ? '0 : cnt_next;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      raw_r   <= in_data.depth_raw;
      final_r <= in_data.frame_final;
      u_cur   <= u_eff;
      v_cur   <= v_eff;
      pc_base <= in_data.frame_first ? '0 : pt_cnt;
      u_sh    <= REM_STEPS'(u_eff);
      v_sh    <= REM_STEPS'(v_eff);
      rem_u   <= '0;
      rem_v   <= '0;
    end
    case (cmd.op)
      OP_REM: begin
        // one restoring step of the stride remainders, offsets from centre
        rem_u <= (t_u >= {1'b0, cs_eff}) ? 8'(t_u - {1'b0, cs_eff}) : t_u[7:0];
        rem_v <= (t_v >= {1'b0, rs_eff}) ? 8'(t_v - {1'b0, rs_eff}) : t_v[7:0];
        u_sh  <= u_sh << 1;
        v_sh  <= v_sh << 1;
        neg_x <= cx > ax;
        neg_y <= cy > ay;
        mag_x <= (cx > ax) ? cx - ax : ax - cx;
        mag_y <= (cy > ay) ? cy - ay : ay - cy;
      end
      OP_ZMUL: zq    <= zsum[ZQ_W+7:8];
      OP_XMAG: magp  <= prod[MAGP_W-1:0];
      OP_YMAG: magp  <= prod[MAGP_W-1:0];
      OP_XLO:  acc_x <= ACC_W'(prod);
      OP_YLO:  acc_y <= ACC_W'(prod);
      OP_XHI:  acc_x <= acc_x + {prod[ACC_W-MUL_W-1:0], {MUL_W{1'b0}}};
      OP_YHI:  acc_y <= acc_y + {prod[ACC_W-MUL_W-1:0], {MUL_W{1'b0}}};
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data.point_valid   <= point_ok;
      out_data.point_x       <= point_ok ? round_sat(acc_x, neg_x) : '0;
      out_data.point_y       <= point_ok ? round_sat(acc_y, neg_y) : '0;
      out_data.point_z       <= point_ok ? zq[Z_W-1:0] : '0;
      out_data.frame_done    <= final_r;
      out_data.points_so_far <= cnt_next;
    end
  end

endmodule

// ===== hdl/depth_pixel_unprojection_core.sv =====
// depth_pixel_unprojection_core: pinhole depth pixel to point unprojection, top level
// each accepted pixel goes through the 12-step stride remainder and seven passes through
// the shared 24x24 multiplier before its result is loaded into the output register; the
// next pixel is accepted only after that, and a waiting result stalls the next one
// reset: synchronous rst clears counters, handshake state and the configuration registers
// depends on dpu_pkg, dpu_cfg_regs, dpu_ctrl, dpu_datapath
module depth_pixel_unprojection_core import dpu_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  pix_in_t               in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output point_out_t            out_data
);

  cfg_t       cfg;
  ctrl_cmd_t  cmd;
  dp_status_t status;

  // configuration registers
  dpu_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // sequencer
  dpu_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // arithmetic and output beat register
  dpu_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd       (cmd),
    .status    (status),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== hdl/dpu_checker.sv =====
// dpu_checker: port-level assertions for depth_pixel_unprojection_core
// bound to the top level below; depends on dpu_pkg
module dpu_checker import dpu_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_stall,
  input logic                  out_valid,
  input logic                  out_stall,
  input point_out_t            out_data
);

  // a stalled output beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("output beat changed while stalled");

  // one pixel at a time: busy right after an accepted beat
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted while previous pixel still in work");

  // a pixel without a point carries zero coordinates
  a_no_point_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.point_valid |->
      out_data.point_x == 0 && out_data.point_y == 0 && out_data.point_z == 0)
    else $error("coordinates nonzero on a pixel without a point");

  // an emitted point is counted
  a_point_counted: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.point_valid |-> out_data.points_so_far != 0)
    else $error("point emitted with zero count");

endmodule

bind depth_pixel_unprojection_core dpu_checker u_dpu_checker (.*);
